// ===== design/ipid_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and command encodings for the incremental PID block.
// No dependencies; imported by the controller, the datapath and the top level.
package ipid_pkg;

  localparam int DATA_W    = 8;
  localparam int IDX_W     = 8;
  localparam int ACC_W     = 16;
  localparam int MUL_W     = 26;
  localparam int PROD_W    = 2 * MUL_W;

  localparam int PWM_TOP   = 199;
  localparam int CTRL_MAX  = 255;
  localparam int SETPOINT_RESET = 70;

  // Truncating divide by ten for magnitudes below 2^16.
  localparam int RCP10       = 52429;
  localparam int RCP10_SHIFT = 19;
  // Truncating divide by CTRL_MAX for values below 2^24.
  localparam int RCP_TOP       = 8421505;
  localparam int RCP_TOP_SHIFT = 31;

  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT  = 8'd0,
    REG_PROP_GAIN = 8'd1,
    REG_PREV_GAIN = 8'd2,
    REG_DIFF_GAIN = 8'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_P,
    OP_RCP,
    OP_ACC_MUL_I,
    OP_ACC_MUL_D,
    OP_ACC,
    OP_CLAMP,
    OP_SCALE,
    OP_RCP_DUTY
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_RCP_P,
    ST_MUL_I,
    ST_RCP_I,
    ST_MUL_D,
    ST_RCP_D,
    ST_ACC_D,
    ST_CLAMP,
    ST_SCALE,
    ST_RCP_DUTY,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== design/incremental_pid_pwm_controller.sv =====
`timescale 1ns / 1ps
// Incremental PID controller with PWM duty output, top level.
// Depends on ipid_pkg, ipid_ctrl and ipid_dp.
//
// Channels:
//   temperature request: in_valid / in_ready, one 8-bit sample per request.
//   result request: out_valid / out_ready, carrying the saturated error, the
//     clamped control value and the PWM compare value.
//   config port: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//     is always high, and writes to indexes beyond diff_gain are dropped.
// Timing: a sample goes through MUL_P, RCP_P, MUL_I, RCP_I, MUL_D, RCP_D,
//   ACC_D, CLAMP, SCALE and RCP_DUTY to DONE, which hands its result to the
//   output register; the next sample is taken only back in idle. The sequencer
//   walks the one shared multiplier through the three gain products, their
//   divides by ten (reciprocal multiplies) and the duty scale-and-divide.
// Stall: the output register holds a result until it is taken; a new sample
//   is accepted meanwhile and its result waits in the final state, with the
//   loop state unchanged, until the output register frees up.
// Reset: setpoint returns to 70, gains to 0, previous error and control to 0,
//   and no result is pending.
module incremental_pid_pwm_controller import ipid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DATA_W-1:0]        temperature,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] error_value,
  output logic [DATA_W-1:0]        control_value,
  output logic [DATA_W-1:0]        duty,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Config registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  ipid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ipid_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .temperature   (temperature),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .error_value   (error_value),
    .control_value (control_value),
    .duty          (duty)
  );

endmodule

// ===== design/ipid_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the incremental PID block: steps the datapath through one sample.
// Depends on ipid_pkg for state, command and status types.
module ipid_ctrl import ipid_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_MUL_P;
      ST_MUL_P:    state_next = ST_RCP_P;
      ST_RCP_P:    state_next = ST_MUL_I;
      ST_MUL_I:    state_next = ST_RCP_I;
      ST_RCP_I:    state_next = ST_MUL_D;
      ST_MUL_D:    state_next = ST_RCP_D;
      ST_RCP_D:    state_next = ST_ACC_D;
      ST_ACC_D:    state_next = ST_CLAMP;
      ST_CLAMP:    state_next = ST_SCALE;
      ST_SCALE:    state_next = ST_RCP_DUTY;
      ST_RCP_DUTY: state_next = ST_DONE;
      ST_DONE:     if (!status.out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL_P:    cmd.op = OP_MUL_P;
      ST_RCP_P:    cmd.op = OP_RCP;
      ST_MUL_I:    cmd.op = OP_ACC_MUL_I;
      ST_RCP_I:    cmd.op = OP_RCP;
      ST_MUL_D:    cmd.op = OP_ACC_MUL_D;
      ST_RCP_D:    cmd.op = OP_RCP;
      ST_ACC_D:    cmd.op = OP_ACC;
      ST_CLAMP:    cmd.op = OP_CLAMP;
      ST_SCALE:    cmd.op = OP_SCALE;
      ST_RCP_DUTY: cmd.op = OP_RCP_DUTY;
      ST_DONE:     cmd.commit = !status.out_busy;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== design/ipid_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the incremental PID block: config registers, shared multiplier,
// accumulator, loop state and the output register. Depends on ipid_pkg.
module ipid_dp import ipid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic [DATA_W-1:0]        temperature,
  input  logic                     cfg_valid,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] error_value,
  output logic [DATA_W-1:0]        control_value,
  output logic [DATA_W-1:0]        duty
);

  logic [DATA_W-1:0] setpoint, prop_gain, prev_gain, diff_gain;
  logic signed [DATA_W-1:0] err, last_error;
  logic [DATA_W-1:0] last_control, ctrl;
  logic signed [ACC_W-1:0] acc;
  logic signed [PROD_W-1:0] mul;
  logic sgn;

  logic signed [DATA_W:0] diff_raw, err_delta;
  logic signed [DATA_W-1:0] err_sat;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [RCP10_SHIFT-2:0] mag;
  logic [ACC_W-1:0] quot;
  logic signed [ACC_W-1:0] term, acc_sum;

  // Config writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint  <= DATA_W'(SETPOINT_RESET);
      prop_gain <= '0;
      prev_gain <= '0;
      diff_gain <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SETPOINT:  setpoint  <= cfg_data;
        REG_PROP_GAIN: prop_gain <= cfg_data;
        REG_PREV_GAIN: prev_gain <= cfg_data;
        REG_DIFF_GAIN: diff_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated error of the incoming sample.
  always_comb begin
    diff_raw = $signed({1'b0, temperature}) - $signed({1'b0, setpoint});
    if (diff_raw > $signed(10'sd127)) begin
      err_sat = 8'sd127;
    end else if (diff_raw < -$signed(10'sd128)) begin
      err_sat = -8'sd128;
    end else begin
      err_sat = diff_raw[DATA_W-1:0];
    end
  end

  assign err_delta = {err[DATA_W-1], err} - {last_error[DATA_W-1], last_error};
  assign mag       = mul[PROD_W-1] ? (RCP10_SHIFT-1)'(-mul) : (RCP10_SHIFT-1)'(mul);
  assign quot      = mul[RCP10_SHIFT +: ACC_W];
  assign term      = sgn ? -$signed(quot) : $signed(quot);
  assign acc_sum   = acc + term;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_P: begin
        mul_a = {{(MUL_W-DATA_W){err[DATA_W-1]}}, err};
        mul_b = {{(MUL_W-DATA_W){1'b0}}, prop_gain};
      end
      OP_RCP: begin
        mul_a = {{(MUL_W-RCP10_SHIFT+1){1'b0}}, mag};
        mul_b = MUL_W'(RCP10);
      end
      OP_ACC_MUL_I: begin
        mul_a = {{(MUL_W-DATA_W){last_error[DATA_W-1]}}, last_error};
        mul_b = {{(MUL_W-DATA_W){1'b0}}, prev_gain};
      end
      OP_ACC_MUL_D: begin
        mul_a = {{(MUL_W-DATA_W-1){err_delta[DATA_W]}}, err_delta};
        mul_b = {{(MUL_W-DATA_W){1'b0}}, diff_gain};
      end
      OP_SCALE: begin
        mul_a = {{(MUL_W-DATA_W){1'b0}}, ctrl};
        mul_b = MUL_W'(PWM_TOP);
      end
      OP_RCP_DUTY: begin
        mul_a = mul[MUL_W-1:0];
        mul_b = MUL_W'(RCP_TOP);
      end
      OP_NONE, OP_ACC, OP_CLAMP: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err <= err_sat;
      acc <= ACC_W'($signed({1'b0, last_control}));
    end
    unique case (cmd.op)
      OP_MUL_P, OP_SCALE, OP_RCP_DUTY: mul <= prod;
      OP_RCP: begin
        sgn <= mul[PROD_W-1];
        mul <= prod;
      end
      OP_ACC_MUL_I, OP_ACC_MUL_D: begin
        acc <= acc_sum;
        mul <= prod;
      end
      OP_ACC: acc <= acc_sum;
      OP_CLAMP: begin
        if (acc < 0) begin
          ctrl <= '0;
        end else if (acc > $signed(ACC_W'(CTRL_MAX))) begin
          ctrl <= DATA_W'(CTRL_MAX);
        end else begin
          ctrl <= acc[DATA_W-1:0];
        end
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  // Loop state advances only when the result is handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error   <= '0;
      last_control <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        last_error   <= err;
        last_control <= ctrl;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      error_value   <= err;
      control_value <= ctrl;
      duty          <= mul[RCP_TOP_SHIFT +: DATA_W];
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== test/incremental_pid_pwm_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the incremental PID controller with PWM duty output.
// Depends on ipid_pkg and incremental_pid_pwm_controller; runs directed and random
// temperature requests against a loop model kept inside this file.
module incremental_pid_pwm_controller_tb;
  import ipid_pkg::*;

  // One result request: saturated error, clamped control, PWM compare value.
  typedef struct packed {
    logic signed [DATA_W-1:0] err;
    logic [DATA_W-1:0]        ctrl;
    logic [DATA_W-1:0]        duty;
  } loop_result_t;

  localparam int GAIN_DIV        = 10;
  localparam int HOLD_OFF_CYCLES = 250;  // long receiver stall, fills the block
  localparam int HOLD_OFF_AFTER  = 400;  // requests taken before the stall starts
  localparam int DRAIN_CYCLES    = 20;   // idle cycles after the last result comes back
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_ITEMS     = 185;
  localparam int QUIET_ITEMS     = 100;
  localparam logic [IDX_W-1:0] IDX_TOP_UNUSED = '1;

  // Directed temperature runs, one per register setting.
  localparam logic [7:0] RUN_RESET [3] = '{8'd0, 8'd255, 8'd70};
  localparam logic [7:0] RUN_HIGH  [7] = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd128, 8'd127, 8'd1};
  localparam logic [7:0] RUN_LOW   [6] = '{8'd0, 8'd0, 8'd255, 8'd254, 8'd128, 8'd0};
  localparam logic [7:0] RUN_MID   [7] = '{8'd129, 8'd127, 8'd200, 8'd60, 8'd128, 8'd255, 8'd0};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [DATA_W-1:0]        temperature = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] error_value;
  logic [DATA_W-1:0]        control_value;
  logic [DATA_W-1:0]        duty;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  incremental_pid_pwm_controller u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .temperature   (temperature),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .error_value   (error_value),
    .control_value (control_value),
    .duty          (duty),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Loop model: registers and the state carried from one sample to the next.
  logic [7:0]        setpoint_m   = 8'(SETPOINT_RESET);
  logic [7:0]        prop_gain_m  = '0;
  logic [7:0]        prev_gain_m  = '0;
  logic [7:0]        diff_gain_m  = '0;
  logic signed [7:0] last_error_m = '0;
  logic [7:0]        last_ctrl_m  = '0;

  logic [7:0]   pending_samples[$];
  loop_result_t expected_results[$];

  int  samples_queued = 0;  // pushed into pending_samples
  int  samples_offered = 0; // put on the input bus by the driver
  int  samples_taken = 0;   // accepted by the block
  int  in_gap = 0;
  int  out_gap = 0;
  int  mismatch_count = 0;
  bit  idle_en = 1'b1;
  bit  rx_hold = 1'b0;

  // Advance the loop by one sample and return what the block must produce.
  function automatic loop_result_t step_pid_loop(input logic [7:0] temp);
    int err, prev_err, p_term, i_term, d_term, ctrl;
    loop_result_t res;
    err = int'(temp) - int'(setpoint_m);
    if (err > 127) err = 127;
    else if (err < -128) err = -128;
    prev_err = int'(last_error_m);
    // SV integer divide truncates toward zero, as the loop requires.
    p_term = (err * int'(prop_gain_m)) / GAIN_DIV;
    i_term = (prev_err * int'(prev_gain_m)) / GAIN_DIV;
    d_term = ((err - prev_err) * int'(diff_gain_m)) / GAIN_DIV;
    ctrl = int'(last_ctrl_m) + p_term + i_term + d_term;
    if (ctrl > CTRL_MAX) ctrl = CTRL_MAX;
    if (ctrl < 0) ctrl = 0;
    res.err  = err[7:0];
    res.ctrl = ctrl[7:0];
    res.duty = 8'((ctrl * PWM_TOP) / CTRL_MAX);
    last_error_m = err[7:0];
    last_ctrl_m  = ctrl[7:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Monitor: sample every handshake at the rising edge, before the block updates.
  always @(posedge clk) begin
    loop_result_t want;
    if (rst) begin
      setpoint_m   = 8'(SETPOINT_RESET);
      prop_gain_m  = '0;
      prev_gain_m  = '0;
      diff_gain_m  = '0;
      last_error_m = '0;
      last_ctrl_m  = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        // Drop writes beyond the last register, as the block does.
        case (cfg_index)
          REG_SETPOINT:  setpoint_m  = cfg_data;
          REG_PROP_GAIN: prop_gain_m = cfg_data;
          REG_PREV_GAIN: prev_gain_m = cfg_data;
          REG_DIFF_GAIN: diff_gain_m = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(step_pid_loop(temperature));
        samples_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result request with nothing pending", int'(control_value), 0);
        end else begin
          want = expected_results.pop_front();
          if (error_value !== want.err)
            report_mismatch("error_value", int'(error_value), int'(want.err));
          if (control_value !== want.ctrl)
            report_mismatch("control_value", int'(control_value), int'(want.ctrl));
          if (duty !== want.duty)
            report_mismatch("duty", int'(duty), int'(want.duty));
        end
      end
    end
  end

  // Temperature driver: a request holds until the monitor counts it as taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || samples_taken == samples_offered) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        temperature <= pending_samples.pop_front();
        in_valid    <= 1'b1;
        samples_offered++;
        if (idle_en && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random short stalls, plus the long hold-off below.
  always @(negedge clk) begin
    if (rst || rx_hold) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_en && $urandom_range(0, 4) == 0) out_gap = $urandom_range(1, 4);
    end
  end

  // Hold the receiver off long enough that the block backs up and stalls its
  // input while the driver keeps offering samples.
  initial begin
    wait (samples_taken >= HOLD_OFF_AFTER);
    rx_hold = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("incremental_pid_pwm_controller_tb NOT OK");
    $finish;
  end

  task automatic offer(input logic [7:0] temp);
    pending_samples.push_back(temp);
    samples_queued++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers, then a stray index when one is given.
  task automatic configure(input logic [7:0] sp, input logic [7:0] kp, input logic [7:0] ki,
                           input logic [7:0] kd, input logic [IDX_W-1:0] stray_idx);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_PREV_GAIN, ki);
    write_reg(REG_DIFF_GAIN, kd);
    if (stray_idx > REG_DIFF_GAIN) write_reg(stray_idx, 8'($urandom_range(0, 255)));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued sample has come back, then let the pipe go quiet.
  task automatic settle;
    while (samples_taken != samples_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(1, 30));
    endcase
  endfunction

  function automatic logic [7:0] pick_setpoint();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // About half the time hover around the setpoint so the loop settles instead of pinning.
  function automatic logic [7:0] pick_temp();
    int t;
    case ($urandom_range(0, 7))
      0: t = $urandom_range(0, 1) ? 255 : 0;
      1, 2, 3: t = $urandom_range(0, 255);
      default: t = int'(setpoint_m) + int'($urandom_range(0, 24)) - 12;
    endcase
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: setpoint 70 and all gains zero keep control at zero.
    foreach (RUN_RESET[k]) offer(RUN_RESET[k]);
    settle();

    // Setpoint at the bottom, gains at the top: positive error saturation and
    // control clamped high, then a sharp drop through the derivative term.
    configure(8'd0, 8'd255, 8'd255, 8'd255, IDX_TOP_UNUSED);
    foreach (RUN_HIGH[k]) offer(RUN_HIGH[k]);
    settle();

    // Setpoint at the top: negative error saturation and control clamped low.
    configure(8'd255, 8'd255, 8'd255, 8'd255, IDX_TOP_UNUSED);
    foreach (RUN_LOW[k]) offer(RUN_LOW[k]);
    settle();

    // Moderate gains: truncating divides on both signs, control inside range.
    configure(8'd128, 8'd10, 8'd1, 8'd5, REG_SETPOINT);
    foreach (RUN_MID[k]) offer(RUN_MID[k]);
    settle();

    // Random settings with random stray writes; the long stall lands in here.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      configure(pick_setpoint(), pick_gain(), pick_gain(), pick_gain(),
                IDX_W'($urandom_range(0, 255)));
      repeat (PHASE_ITEMS) offer(pick_temp());
      settle();
    end

    // Finish with both sides running flat out.
    idle_en = 1'b0;
    configure(pick_setpoint(), pick_gain(), pick_gain(), pick_gain(),
              IDX_W'($urandom_range(0, 255)));
    repeat (QUIET_ITEMS) offer(pick_temp());
    settle();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("incremental_pid_pwm_controller_tb OK");
    end else begin
      $display("incremental_pid_pwm_controller_tb NOT OK");
    end
    $finish;
  end

endmodule
